// File: rtl/core/pfmm_pkg.sv
// Package for the pulse frequency median meter: item types, register
// indexes, ring sizing and arithmetic constants. No dependencies.
`timescale 1ns / 1ps

package pfmm_pkg;

   localparam int RING_DEPTH = 8;
   localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int MID_HI     = RING_DEPTH / 2;
   localparam int MID_LO     = (RING_DEPTH % 2 == 1) ? RING_DEPTH / 2 : RING_DEPTH / 2 - 1;
   localparam bit MED_ODD    = (RING_DEPTH % 2 == 1);

   localparam int FREQ_W = 28;
   localparam int DIV_STEPS = FREQ_W;
   localparam logic [FREQ_W-1:0] FREQ_MAX = 28'hFFFFFFF;
   localparam logic [FREQ_W-1:0] FREQ_NUM = 28'd256000000;

   localparam int CSR_IW = 3;
   localparam logic [CSR_IW-1:0] CSR_EXTRA_TIMEOUT = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_STALE_LIMIT   = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_THRESHOLD     = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_SAMPLE_PERIOD = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_COUNT_RELOAD  = 3'd4;

   localparam logic REQ_EDGE = 1'b0;
   localparam logic REQ_POLL = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [31:0] now_us;
      logic [31:0] now_ms;
   } req_item_type;

   typedef struct packed {
      logic [FREQ_W-1:0] freq_q8;
      logic [FREQ_W-1:0] median_q8;
      logic              working;
      logic [7:0]        down_count;
      logic              timed_out;
   } rsp_item_type;

endpackage

// File: rtl/core/pulse_frequency_median_meter.sv
// Pulse frequency meter with median ring: top level sequencer.
// Uses pfmm_pkg and pfmm_div.
// A pulse edge item records its interval and goes straight to the result register; a poll
// that is not dead runs the 28-step serial divider (skipped for a zero interval) and the
// one-compare-per-cycle median rank search before its result is registered. One item at
// a time; req_stall is high from acceptance until the result is registered. Reset
// (synchronous) clears state and ring, loads register defaults.
`timescale 1ns / 1ps

module pulse_frequency_median_meter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pfmm_pkg::req_item_type         req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pfmm_pkg::rsp_item_type         rsp_data,
   input  logic                           csr_we,
   input  logic [pfmm_pkg::CSR_IW-1:0]    csr_index,
   input  logic [31:0]                    csr_wdata
);

   localparam int AW = pfmm_pkg::RING_AW;
   localparam int FW = pfmm_pkg::FREQ_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_STALE, ST_CHECK, ST_DIVWAIT, ST_SAMPLE,
      ST_MLOAD, ST_MCMP, ST_MFIN, ST_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] extra_ff, stale_ff, period_ff;
   logic [FW-1:0] thresh_ff;
   logic [7:0]  reload_ff;

   logic [31:0] last_edge_ff, last_edge_in;
   logic [31:0] interval_ff, interval_in;
   logic [FW-1:0] freq_ff, freq_in;
   logic [FW-1:0] median_ff, median_in;
   logic [FW-1:0] ring_ff [pfmm_pkg::RING_DEPTH];
   logic [FW-1:0] ring_in [pfmm_pkg::RING_DEPTH];
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [31:0] last_sample_ff, last_sample_in;
   logic        working_ff, working_in;
   logic [7:0]  down_ff, down_in;
   logic        timed_ff, timed_in;
   logic [31:0] now_us_ff, now_us_in;
   logic [31:0] now_ms_ff, now_ms_in;

   logic [AW-1:0] mi_ff, mi_in, mj_ff, mj_in, rank_ff, rank_in;
   logic [FW-1:0] cand_ff, cand_in, lo_ff, lo_in, hi_ff, hi_in;

   logic        rsp_valid_ff, rsp_valid_in;
   pfmm_pkg::rsp_item_type rsp_ff, rsp_in;

   logic        div_start, div_busy, div_done;
   logic [FW-1:0] div_quo;

   logic [31:0] since;
   logic [32:0] limit;
   logic [FW-1:0] rd_val;
   logic        less;
   logic [AW-1:0] rank_next;
   logic [FW:0]  mid_sum;
   logic [7:0]  dec;

   localparam logic [AW-1:0] IDX_LAST = AW'(pfmm_pkg::RING_DEPTH - 1);

   pfmm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (interval_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         extra_ff  <= 32'd200000;
         stale_ff  <= 32'd1000000;
         thresh_ff <= 28'd12800;
         period_ff <= 32'd100;
         reload_ff <= 8'd4;
      end else if (csr_we) begin
         case (csr_index)
            pfmm_pkg::CSR_EXTRA_TIMEOUT: extra_ff  <= csr_wdata;
            pfmm_pkg::CSR_STALE_LIMIT:   stale_ff  <= csr_wdata;
            pfmm_pkg::CSR_THRESHOLD:     thresh_ff <= csr_wdata[FW-1:0];
            pfmm_pkg::CSR_SAMPLE_PERIOD: period_ff <= csr_wdata;
            pfmm_pkg::CSR_COUNT_RELOAD:  reload_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      last_edge_in   = last_edge_ff;
      interval_in    = interval_ff;
      freq_in        = freq_ff;
      median_in      = median_ff;
      ring_in        = ring_ff;
      ptr_in         = ptr_ff;
      last_sample_in = last_sample_ff;
      working_in     = working_ff;
      down_in        = down_ff;
      timed_in       = timed_ff;
      now_us_in      = now_us_ff;
      now_ms_in      = now_ms_ff;
      mi_in          = mi_ff;
      mj_in          = mj_ff;
      rank_in        = rank_ff;
      cand_in        = cand_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_in         = rsp_ff;
      div_start      = 1'b0;

      since     = now_us_ff - last_edge_ff;
      limit     = {1'b0, interval_ff} + {1'b0, extra_ff};
      rd_val    = ring_ff[(state_ff == ST_MLOAD) ? mi_ff : mj_ff];
      // rank ties by ring position so every entry gets a distinct rank
      less      = (rd_val < cand_ff) || ((rd_val == cand_ff) && (mj_ff < mi_ff));
      rank_next = rank_ff + AW'(less);
      mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
      dec       = down_ff - 8'd1;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_us_in = req_data.now_us;
               now_ms_in = req_data.now_ms;
               timed_in  = 1'b0;
               if (req_data.req_type == pfmm_pkg::REQ_EDGE) begin
                  interval_in  = req_data.now_us - last_edge_ff;
                  last_edge_in = req_data.now_us;
                  state_in     = ST_OUT;
               end else begin
                  state_in = ST_STALE;
               end
            end
         end
         ST_STALE: begin
            if (interval_ff > stale_ff) begin
               interval_in = '0;
            end
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if ({1'b0, since} > limit) begin
               freq_in  = '0;
               timed_in = 1'b1;
               state_in = ST_OUT;
            end else if (interval_ff == 32'd0) begin
               freq_in  = pfmm_pkg::FREQ_MAX;
               state_in = ST_SAMPLE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVWAIT;
            end
         end
         ST_DIVWAIT: begin
            if (div_done) begin
               freq_in  = div_quo;
               state_in = ST_SAMPLE;
            end
         end
         ST_SAMPLE: begin
            if ((now_ms_ff - last_sample_ff) >= period_ff) begin
               ring_in[ptr_ff] = freq_ff;
               ptr_in          = (ptr_ff == IDX_LAST) ? '0 : ptr_ff + AW'(1);
               last_sample_in  = now_ms_ff;
            end
            mi_in    = '0;
            state_in = ST_MLOAD;
         end
         ST_MLOAD: begin
            cand_in  = rd_val;
            rank_in  = '0;
            mj_in    = '0;
            state_in = ST_MCMP;
         end
         ST_MCMP: begin
            rank_in = rank_next;
            mj_in   = mj_ff + AW'(1);
            if (mj_ff == IDX_LAST) begin
               if (rank_next == AW'(pfmm_pkg::MID_LO)) lo_in = cand_ff;
               if (rank_next == AW'(pfmm_pkg::MID_HI)) hi_in = cand_ff;
               mi_in = mi_ff + AW'(1);
               state_in = (mi_ff == IDX_LAST) ? ST_MFIN : ST_MLOAD;
            end
         end
         ST_MFIN: begin
            median_in = pfmm_pkg::MED_ODD ? hi_ff : mid_sum[FW:1];
            if ((freq_ff > thresh_ff) && !working_ff) begin
               working_in = 1'b1;
               down_in    = (dec == 8'd0) ? reload_ff : dec;
            end else if ((freq_ff <= thresh_ff) && working_ff) begin
               working_in = 1'b0;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_in.freq_q8    = freq_ff;
               rsp_in.median_q8  = median_ff;
               rsp_in.working    = working_ff;
               rsp_in.down_count = down_ff;
               rsp_in.timed_out  = timed_ff;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         last_edge_ff   <= '0;
         interval_ff    <= '0;
         freq_ff        <= '0;
         median_ff      <= '0;
         for (int k = 0; k < pfmm_pkg::RING_DEPTH; k++) begin
            ring_ff[k] <= '0;
         end
         ptr_ff         <= '0;
         last_sample_ff <= '0;
         working_ff     <= 1'b0;
         down_ff        <= 8'd4;
         timed_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         last_edge_ff   <= last_edge_in;
         interval_ff    <= interval_in;
         freq_ff        <= freq_in;
         median_ff      <= median_in;
         ring_ff        <= ring_in;
         ptr_ff         <= ptr_in;
         last_sample_ff <= last_sample_in;
         working_ff     <= working_in;
         down_ff        <= down_in;
         timed_ff       <= timed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      now_us_ff <= now_us_in;
      now_ms_ff <= now_ms_in;
      mi_ff     <= mi_in;
      mj_ff     <= mj_in;
      rank_ff   <= rank_in;
      cand_ff   <= cand_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.timed_out || rsp_ff.freq_q8 == '0))
      else $error("timed-out result with nonzero frequency");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVWAIT) |-> (div_busy || div_done))
      else $error("waiting on an idle divider");
   a_new_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output step");
`endif

endmodule

// File: rtl/core/pfmm_div.sv
// Bit-serial restoring divider: fixed dividend over a 32-bit divisor,
// one quotient bit per cycle. Uses pfmm_pkg.
`timescale 1ns / 1ps

module pfmm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [31:0]                divisor,
   output logic                       busy,
   output logic                       done,
   output logic [pfmm_pkg::FREQ_W-1:0] quotient
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [4:0]                  cnt_ff, cnt_in;
   logic [31:0]                 rem_ff, rem_in;
   logic [31:0]                 dvs_ff, dvs_in;
   logic [pfmm_pkg::FREQ_W-1:0] quo_ff, quo_in;
   logic [32:0]                 trial;
   logic [32:0]                 diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[pfmm_pkg::FREQ_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'(pfmm_pkg::DIV_STEPS - 1);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = pfmm_pkg::FREQ_NUM;
      end else if (busy_ff) begin
         // shift the next dividend bit in, keep the quotient bit in its place
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[pfmm_pkg::FREQ_W-2:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[pfmm_pkg::FREQ_W-2:0], 1'b0};
         end
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: tb/pfmm_checker.sv
// Checker for the pulse frequency median meter: watches the request, result
// and register ports, predicts each result and compares field by field.
// Depends on pfmm_pkg.
`timescale 1ns / 1ps

module pfmm_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  pfmm_pkg::req_item_type      req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  pfmm_pkg::rsp_item_type      rsp_data,
   input  logic                        csr_we,
   input  logic [pfmm_pkg::CSR_IW-1:0] csr_index,
   input  logic [31:0]                 csr_wdata,
   output int                          fail_count,
   output int                          pending
);

   // register mirror
   logic [31:0]                 extra_timeout;
   logic [31:0]                 stale_limit;
   logic [pfmm_pkg::FREQ_W-1:0] threshold;
   logic [31:0]                 sample_period;
   logic [7:0]                  count_reload;

   // meter state mirror
   logic [31:0]                  last_edge;
   logic [31:0]                  interval;
   logic [pfmm_pkg::FREQ_W-1:0]  freq;
   logic [pfmm_pkg::FREQ_W-1:0]  median;
   logic [pfmm_pkg::FREQ_W-1:0]  ring [pfmm_pkg::RING_DEPTH];
   logic [pfmm_pkg::RING_AW-1:0] ring_ptr;
   logic [31:0]                  last_sample;
   logic                         working;
   logic [7:0]                   down_cnt;

   int fail_total = 0;

   pfmm_pkg::rsp_item_type predicted_rsp_q[$];

   assign fail_count = fail_total;

   function automatic logic [pfmm_pkg::FREQ_W-1:0] ring_median();
      logic [pfmm_pkg::FREQ_W-1:0] s [pfmm_pkg::RING_DEPTH];
      logic [pfmm_pkg::FREQ_W-1:0] v;
      logic [pfmm_pkg::FREQ_W:0]   sum;
      int j;
      for (int i = 0; i < pfmm_pkg::RING_DEPTH; i++) s[i] = ring[i];
      for (int i = 1; i < pfmm_pkg::RING_DEPTH; i++) begin
         v = s[i];
         j = i;
         while (j > 0 && s[j-1] > v) begin
            s[j] = s[j-1];
            j--;
         end
         s[j] = v;
      end
      sum = {1'b0, s[pfmm_pkg::MID_LO]} + {1'b0, s[pfmm_pkg::MID_HI]};
      return pfmm_pkg::MED_ODD ? s[pfmm_pkg::MID_HI] : sum[pfmm_pkg::FREQ_W:1];
   endfunction

   task automatic predict_meter(input pfmm_pkg::req_item_type r);
      pfmm_pkg::rsp_item_type p;
      logic [31:0]  since;
      logic [32:0]  limit;
      logic         dead;
      dead = 1'b0;
      if (r.req_type == pfmm_pkg::REQ_EDGE) begin
         interval  = r.now_us - last_edge;
         last_edge = r.now_us;
      end else begin
         if (interval > stale_limit) interval = '0;
         since = r.now_us - last_edge;
         limit = {1'b0, interval} + {1'b0, extra_timeout};
         if ({1'b0, since} > limit) begin
            freq = '0;
            dead = 1'b1;
         end else begin
            freq = (interval == 0) ? pfmm_pkg::FREQ_MAX
                                   : pfmm_pkg::FREQ_W'(32'd256000000 / interval);
            if (32'(r.now_ms - last_sample) >= sample_period) begin
               ring[ring_ptr] = freq;
               ring_ptr = (ring_ptr == pfmm_pkg::RING_DEPTH - 1) ? '0 : ring_ptr + 1'b1;
               last_sample = r.now_ms;
            end
            median = ring_median();
            if (freq > threshold && !working) begin
               working  = 1'b1;
               down_cnt = down_cnt - 8'd1;
               if (down_cnt == 0) down_cnt = count_reload;
            end else if (freq <= threshold && working) begin
               working = 1'b0;
            end
         end
      end
      p.freq_q8    = freq;
      p.median_q8  = median;
      p.working    = working;
      p.down_count = down_cnt;
      p.timed_out  = dead;
      predicted_rsp_q.push_back(p);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      fail_total++;
   endtask

   always @(posedge clock) begin
      pfmm_pkg::rsp_item_type w;
      if (reset) begin
         extra_timeout = 32'd200000;
         stale_limit   = 32'd1000000;
         threshold     = 28'd12800;
         sample_period = 32'd100;
         count_reload  = 8'd4;
         last_edge = '0;
         interval  = '0;
         freq      = '0;
         median    = '0;
         for (int i = 0; i < pfmm_pkg::RING_DEPTH; i++) ring[i] = '0;
         ring_ptr    = '0;
         last_sample = '0;
         working     = 1'b0;
         down_cnt    = 8'd4;
         predicted_rsp_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               pfmm_pkg::CSR_EXTRA_TIMEOUT: extra_timeout = csr_wdata;
               pfmm_pkg::CSR_STALE_LIMIT:   stale_limit   = csr_wdata;
               pfmm_pkg::CSR_THRESHOLD:     threshold     = csr_wdata[pfmm_pkg::FREQ_W-1:0];
               pfmm_pkg::CSR_SAMPLE_PERIOD: sample_period = csr_wdata;
               pfmm_pkg::CSR_COUNT_RELOAD:  count_reload  = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp_q.size() == 0) begin
               report_mismatch("unexpected item", rsp_data.freq_q8, 0);
            end else begin
               w = predicted_rsp_q.pop_front();
               if (rsp_data.freq_q8 !== w.freq_q8)
                  report_mismatch("freq_q8", rsp_data.freq_q8, w.freq_q8);
               if (rsp_data.median_q8 !== w.median_q8)
                  report_mismatch("median_q8", rsp_data.median_q8, w.median_q8);
               if (rsp_data.working !== w.working)
                  report_mismatch("working", rsp_data.working, w.working);
               if (rsp_data.down_count !== w.down_count)
                  report_mismatch("down_count", rsp_data.down_count, w.down_count);
               if (rsp_data.timed_out !== w.timed_out)
                  report_mismatch("timed_out", rsp_data.timed_out, w.timed_out);
            end
         end
         if (req_valid && !req_stall) predict_meter(req_data);
      end
      pending = predicted_rsp_q.size();
   end

endmodule

// File: tb/pulse_frequency_median_meter_tb.sv
// Testbench top for the pulse frequency median meter: clock, reset, register
// phases and request stimulus; checking is done by pfmm_checker.
// Depends on pfmm_pkg, pulse_frequency_median_meter and pfmm_checker.
`timescale 1ns / 1ps

module pulse_frequency_median_meter_tb;

   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 340;
   localparam int SETTLE_CYCLES = 150;
   // index with no register behind it
   localparam logic [pfmm_pkg::CSR_IW-1:0] CSR_NO_REG = 3'd7;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   pfmm_pkg::req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   pfmm_pkg::rsp_item_type rsp_data;
   logic         csr_we;
   logic [pfmm_pkg::CSR_IW-1:0] csr_index;
   logic [31:0]  csr_wdata;
   int           fail_count;
   int           pending;

   int           send_idle_pct;
   int           stall_pct;
   logic [31:0]  cur_us;
   logic [31:0]  cur_ms;
   logic [31:0]  pulse_period;

   // per phase: extra timeout, stale limit, threshold, sample period, reload
   logic [31:0] phase_cfg [PHASES][5] = '{
      '{32'd200000,   32'd1000000,  32'd12800,    32'd100,      32'd4},
      '{32'd0,        32'd0,        32'd0,        32'd0,        32'd1},
      '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0FFFFFFF, 32'hFFFFFFFF, 32'd255},
      '{32'd50000,    32'd300000,   32'd25600,    32'd10,       32'd3},
      '{32'd1000,     32'd50000,    32'd1000000,  32'd1,        32'd7},
      '{32'd200000,   32'd2000000,  32'd12800,    32'd100,      32'd2}
   };
   int phase_idle [PHASES][2] = '{'{0, 0}, '{88, 0}, '{0, 88}, '{10, 10}, '{0, 0}, '{88, 88}};

   pulse_frequency_median_meter uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pfmm_checker meter_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver stall, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_item(input logic kind, input logic [31:0] us, input logic [31:0] ms);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_data.req_type <= kind;
      req_data.now_us   <= us;
      req_data.now_ms   <= ms;
      // stall only changes at the rising edge; the item goes at the first edge seen free
      while (req_stall) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [pfmm_pkg::CSR_IW-1:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly a steady pulse train with polls; some dead gaps and raw noise
   task automatic send_random();
      int r;
      r = $urandom_range(99);
      if ($urandom_range(49) == 0) begin
         case ($urandom_range(2))
            0: pulse_period = $urandom_range(300);
            1: pulse_period = $urandom_range(60000, 300);
            default: pulse_period = $urandom_range(3000000);
         endcase
      end
      if (r < 45) begin
         cur_us = cur_us + pulse_period + $urandom_range(pulse_period / 8);
         cur_ms = cur_ms + $urandom_range(40);
         send_item(pfmm_pkg::REQ_EDGE, cur_us, cur_ms);
      end else if (r < 90) begin
         cur_us = cur_us + $urandom_range(pulse_period / 2);
         cur_ms = cur_ms + $urandom_range(150);
         send_item(pfmm_pkg::REQ_POLL, cur_us, cur_ms);
      end else if (r < 95) begin
         cur_us = cur_us + $urandom_range(32'h7FFFFFFF);
         send_item(pfmm_pkg::REQ_POLL, cur_us, cur_ms);
      end else begin
         send_item(1'($urandom_range(1)), $urandom, $urandom);
      end
   endtask

   initial begin
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      stall_pct = 0;
      send_idle_pct = 0;
      cur_us = '0;
      cur_ms = '0;
      pulse_period = 32'd20000;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zero interval, tiny interval, threshold crossings, staleness,
      // dead input, timestamp wrap and all-ones fields, default registers
      send_item(pfmm_pkg::REQ_POLL, 32'd0,        32'd0);
      send_item(pfmm_pkg::REQ_EDGE, 32'd0,        32'd0);
      send_item(pfmm_pkg::REQ_POLL, 32'd0,        32'd100);
      send_item(pfmm_pkg::REQ_EDGE, 32'd1,        32'd200);
      send_item(pfmm_pkg::REQ_POLL, 32'd1,        32'd300);
      send_item(pfmm_pkg::REQ_EDGE, 32'd20001,    32'd320);
      send_item(pfmm_pkg::REQ_POLL, 32'd20001,    32'd420);
      send_item(pfmm_pkg::REQ_EDGE, 32'd30001,    32'd430);
      send_item(pfmm_pkg::REQ_POLL, 32'd30002,    32'd530);
      send_item(pfmm_pkg::REQ_EDGE, 32'd50001,    32'd550);
      send_item(pfmm_pkg::REQ_POLL, 32'd50001,    32'd650);
      send_item(pfmm_pkg::REQ_EDGE, 32'd2050001,  32'd2650);
      send_item(pfmm_pkg::REQ_POLL, 32'd2050001,  32'd2750);
      send_item(pfmm_pkg::REQ_POLL, 32'd2250002,  32'd2850);
      send_item(pfmm_pkg::REQ_EDGE, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_item(pfmm_pkg::REQ_EDGE, 32'd9,        32'd5);
      send_item(pfmm_pkg::REQ_POLL, 32'd10,       32'd200);
      send_item(pfmm_pkg::REQ_POLL, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_item(pfmm_pkg::REQ_EDGE, 32'd4000,     32'd0);
      send_item(pfmm_pkg::REQ_POLL, 32'd4000,     32'd100);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         write_reg(pfmm_pkg::CSR_EXTRA_TIMEOUT, phase_cfg[p][0]);
         write_reg(pfmm_pkg::CSR_STALE_LIMIT,   phase_cfg[p][1]);
         write_reg(pfmm_pkg::CSR_THRESHOLD,     phase_cfg[p][2]);
         write_reg(pfmm_pkg::CSR_SAMPLE_PERIOD, phase_cfg[p][3]);
         write_reg(pfmm_pkg::CSR_COUNT_RELOAD,  phase_cfg[p][4]);
         write_reg(CSR_NO_REG, $urandom);
         send_idle_pct = phase_idle[p][0];
         stall_pct     = phase_idle[p][1];
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // hold off once until the block has answered everything
            if (p == 3 && i == PHASE_ITEMS / 2) wait_drained();
            send_random();
         end
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
